[design/i2crms_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// i2crms_pkg: shared types, field map and defaults
// Field map of the staged register store, payload structs, controller
// command and status structs, and lookup functions.
// ----------------------------------------------------------------------------
package i2crms_pkg;

  // sizes of the store and its field map
  localparam int STORE_BYTES     = 76;
  localparam int FIELD_COUNT     = 23;
  localparam int MAX_FIELD_BYTES = 4;

  localparam int ADDR_W = 7;
  localparam int DATA_W = 8;
  localparam int FIELD_W = 5;
  localparam int LEN_W  = $clog2(MAX_FIELD_BYTES + 1);
  localparam int SIDX_W = (MAX_FIELD_BYTES > 1) ? $clog2(MAX_FIELD_BYTES) : 1;

  localparam logic [FIELD_W-1:0] NO_FIELD = 5'd31;

  // bus access codes
  localparam logic CMD_READ  = 1'b0;
  localparam logic CMD_WRITE = 1'b1;

  // field map: first byte and length of each field
  localparam logic [ADDR_W-1:0] FIELD_OFFSET [FIELD_COUNT] = '{
    7'd0,  7'd2,  7'd4,  7'd8,  7'd12, 7'd13, 7'd17, 7'd21, 7'd25, 7'd29, 7'd33, 7'd37,
    7'd41, 7'd45, 7'd49, 7'd53, 7'd57, 7'd61, 7'd65, 7'd69, 7'd70, 7'd72, 7'd74
  };
  localparam logic [LEN_W-1:0] FIELD_LEN [FIELD_COUNT] = '{
    3'd2, 3'd2, 3'd4, 3'd4, 3'd1, 3'd4, 3'd4, 3'd4, 3'd4, 3'd4, 3'd4, 3'd4,
    3'd4, 3'd4, 3'd4, 3'd4, 3'd4, 3'd4, 3'd4, 3'd1, 3'd2, 3'd2, 3'd2
  };

  // payload of one access item
  typedef struct packed {
    logic              command;
    logic [ADDR_W-1:0] byte_address;
    logic [DATA_W-1:0] write_data;
  } access_t;

  // payload of one reply item
  typedef struct packed {
    logic [DATA_W-1:0]  read_data;
    logic               more_allowed;
    logic               field_committed;
    logic [FIELD_W-1:0] field_index;
  } reply_t;

  // address to field lookup result
  typedef struct packed {
    logic               hit;
    logic [FIELD_W-1:0] index;
  } field_hit_t;

  // controller to datapath commands
  typedef struct packed {
    logic             capture;
    logic             decode;
    logic             load_rd;
    logic             load_cap;
    logic             load_done;
    logic             exec;
    logic             commit_wr;
    logic             out_load;
    logic [LEN_W-1:0] cnt;
  } ctrl_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic             hit;
    logic             field_change;
    logic [LEN_W-1:0] len;
    logic             commit_now;
    logic             out_free;
  } ctrl_sts_t;

  // find the field that holds a byte address
  function automatic field_hit_t field_of(input logic [ADDR_W-1:0] addr);
    field_hit_t r;
    logic [ADDR_W:0] top;
    r = '0;
    for (int f = 0; f < FIELD_COUNT; f++) begin
      top = {1'b0, FIELD_OFFSET[f]} + (ADDR_W+1)'(FIELD_LEN[f]);
      if (addr >= FIELD_OFFSET[f] && {1'b0, addr} < top) begin
        r.hit   = 1'b1;
        r.index = FIELD_W'(f);
      end
    end
    return r;
  endfunction

  // field length limited to the shadow size
  function automatic logic [LEN_W-1:0] clip_len(input logic [FIELD_W-1:0] idx);
    logic [LEN_W-1:0] n;
    n = FIELD_LEN[idx];
    return (n > LEN_W'(MAX_FIELD_BYTES)) ? LEN_W'(MAX_FIELD_BYTES) : n;
  endfunction

  // firmware default contents of the store, little endian
  function automatic logic [DATA_W-1:0] store_default(input logic [ADDR_W-1:0] addr);
    logic [DATA_W-1:0] b;
    case (addr)
      7'd4:    b = 8'h53;
      7'd5:    b = 8'h29;
      7'd6:    b = 8'h72;
      7'd7:    b = 8'h46;
      7'd8:    b = 8'hDC;
      7'd9:    b = 8'h2E;
      7'd10:   b = 8'h34;
      7'd11:   b = 8'h3E;
      7'd25:   b = 8'h00;
      7'd26:   b = 8'hFE;
      7'd27:   b = 8'hFF;
      7'd28:   b = 8'hC6;
      7'd29:   b = 8'h00;
      7'd30:   b = 8'hFE;
      7'd31:   b = 8'hFF;
      7'd32:   b = 8'h46;
      7'd74:   b = 8'hB8;
      7'd75:   b = 8'h0B;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage
`default_nettype wire

[design/i2crms_ram.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// i2crms_ram: generic simple dual-port ram
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module i2crms_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 76
) (
  input  wire                       clk,
  input  logic                      we,
  input  logic [$clog2(DEPTH)-1:0]  wr_addr,
  input  logic [WIDTH-1:0]          wr_data,
  input  logic                      re,
  input  logic [$clog2(DEPTH)-1:0]  rd_addr,
  output logic [WIDTH-1:0]          rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    if (re) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

[design/i2crms_ctrl.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// i2crms_ctrl: access sequencer
// Steps one item through decode, field load, execute, commit and reply.
// ----------------------------------------------------------------------------
module i2crms_ctrl import i2crms_pkg::*; (
  input  wire        clk,
  input  wire        rst,
  input  logic       access_valid,
  output logic       access_ready,
  input  ctrl_sts_t  sts,
  output ctrl_cmd_t  cmd
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DECODE = 3'd1;
  localparam logic [2:0] S_LOAD   = 3'd2;
  localparam logic [2:0] S_EXEC   = 3'd3;
  localparam logic [2:0] S_COMMIT = 3'd4;
  localparam logic [2:0] S_DONE   = 3'd5;

  logic [2:0]       state;
  logic [2:0]       state_next;
  logic [LEN_W-1:0] cnt;
  logic [LEN_W-1:0] cnt_next;

  // next state and command decode
  always_comb begin
    state_next   = state;
    cnt_next     = cnt;
    access_ready = 1'b0;
    cmd          = '0;
    cmd.cnt      = cnt;
    case (state)
      S_IDLE: begin
        access_ready = 1'b1;
        if (access_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_DECODE;
        end
      end
      S_DECODE: begin
        cmd.decode = 1'b1;
        cnt_next   = '0;
        if (!sts.hit) begin
          state_next = S_DONE;
        end else if (sts.field_change) begin
          state_next = S_LOAD;
        end else begin
          state_next = S_EXEC;
        end
      end
      S_LOAD: begin
        cmd.load_rd  = (cnt < sts.len);
        cmd.load_cap = (cnt != '0);
        if (cnt == sts.len) begin
          cmd.load_done = 1'b1;
          state_next    = S_EXEC;
        end else begin
          cnt_next = cnt + LEN_W'(1);
        end
      end
      S_EXEC: begin
        cmd.exec = 1'b1;
        cnt_next = '0;
        if (sts.commit_now) begin
          state_next = S_COMMIT;
        end else begin
          state_next = S_DONE;
        end
      end
      S_COMMIT: begin
        cmd.commit_wr = 1'b1;
        if (cnt == sts.len - LEN_W'(1)) begin
          state_next = S_DONE;
        end else begin
          cnt_next = cnt + LEN_W'(1);
        end
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

endmodule
`default_nettype wire

[design/i2crms_dp.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// i2crms_dp: store, shadow buffer and reply datapath
// Holds the register store ram with per-byte default tracking, the field
// shadow, fill and field tracking, and the reply output register.
// ----------------------------------------------------------------------------
module i2crms_dp import i2crms_pkg::*; (
  input  wire        clk,
  input  wire        rst,
  input  access_t    access,
  input  logic       reply_ready,
  input  ctrl_cmd_t  cmd,
  output ctrl_sts_t  sts,
  output reply_t     reply,
  output logic       reply_valid
);

  access_t            item;
  logic [FIELD_W-1:0] fld_q;
  logic [ADDR_W-1:0]  off_q;
  logic [LEN_W-1:0]   len_q;
  logic [DATA_W-1:0]  shadow [MAX_FIELD_BYTES];
  logic [ADDR_W-1:0]  base;
  logic [LEN_W-1:0]   fill;
  logic [FIELD_W-1:0] last_field;
  reply_t             res;
  logic [STORE_BYTES-1:0] written;
  logic               rd_written_q;
  logic [DATA_W-1:0]  rd_default_q;

  field_hit_t         hit;
  logic [ADDR_W:0]    addr_inc;
  logic [ADDR_W-1:0]  rd_addr;
  logic [ADDR_W-1:0]  wr_addr;
  logic [DATA_W-1:0]  wr_data;
  logic [DATA_W-1:0]  ram_q;
  logic [DATA_W-1:0]  rd_byte;
  logic [ADDR_W-1:0]  rd_off;
  logic [SIDX_W-1:0]  cap_idx;
  logic [SIDX_W-1:0]  widx;
  logic [LEN_W-1:0]   fill_inc;
  logic               is_write;

  // field lookup and address arithmetic
  assign hit      = field_of(item.byte_address);
  assign addr_inc = {1'b0, item.byte_address} + (ADDR_W+1)'(1);
  assign rd_addr  = off_q + ADDR_W'(cmd.cnt);
  assign wr_addr  = base + ADDR_W'(cmd.cnt);
  assign wr_data  = shadow[cmd.cnt[SIDX_W-1:0]];
  assign rd_off   = item.byte_address - base;
  assign cap_idx  = SIDX_W'(cmd.cnt - LEN_W'(1));
  assign is_write = (item.command == CMD_WRITE);

  // write slot: a stale fill count restarts at the first shadow byte
  assign widx     = (fill >= len_q) ? '0 : fill[SIDX_W-1:0];
  assign fill_inc = LEN_W'(widx) + LEN_W'(1);

  // never-written store bytes read as their firmware default
  assign rd_byte = rd_written_q ? ram_q : rd_default_q;

  // status to the sequencer
  assign sts.hit          = hit.hit;
  assign sts.field_change = (hit.index != last_field);
  assign sts.len          = len_q;
  assign sts.commit_now   = is_write && (fill_inc == len_q);
  assign sts.out_free     = !reply_valid || reply_ready;

  i2crms_ram #(
    .WIDTH (DATA_W),
    .DEPTH (STORE_BYTES)
  ) u_store (
    .clk     (clk),
    .we      (cmd.commit_wr),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .re      (cmd.load_rd),
    .rd_addr (rd_addr),
    .rd_data (ram_q)
  );

  // field tracking, fill count, written flags and reply valid
  always_ff @(posedge clk) begin
    if (rst) begin
      base        <= '0;
      fill        <= '0;
      last_field  <= NO_FIELD;
      written     <= '0;
      reply_valid <= 1'b0;
    end else begin
      if (cmd.load_done) begin
        base       <= off_q;
        last_field <= fld_q;
        if (is_write) begin
          fill <= '0;
        end
      end
      if (cmd.exec && is_write) begin
        fill <= sts.commit_now ? '0 : fill_inc;
      end
      if (cmd.commit_wr) begin
        written[wr_addr] <= 1'b1;
      end
      if (cmd.out_load) begin
        reply_valid <= 1'b1;
      end else if (reply_ready) begin
        reply_valid <= 1'b0;
      end
    end
  end

  // item, field decode, shadow and reply payload
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item <= access;
    end
    if (cmd.decode) begin
      fld_q                 <= hit.index;
      off_q                 <= FIELD_OFFSET[hit.index];
      len_q                 <= clip_len(hit.index);
      res.read_data         <= '0;
      res.field_committed   <= 1'b0;
      res.field_index       <= hit.hit ? hit.index : '0;
      res.more_allowed      <= hit.hit && (addr_inc < (ADDR_W+1)'(STORE_BYTES));
    end
    if (cmd.load_rd) begin
      rd_written_q <= written[rd_addr];
      rd_default_q <= store_default(rd_addr);
    end
    if (cmd.load_cap) begin
      shadow[cap_idx] <= rd_byte;
    end
    if (cmd.exec) begin
      if (is_write) begin
        shadow[widx]        <= item.write_data;
        res.field_committed <= sts.commit_now;
      end else begin
        res.read_data <= shadow[rd_off[SIDX_W-1:0]];
      end
    end
    if (cmd.out_load) begin
      reply <= res;
    end
  end

endmodule
`default_nettype wire

[design/i2c_register_map_staging_unit.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// i2c_register_map_staging_unit: byte access to a field-mapped register store
// Path from access to reply: capture and decode, then straight to the reply
// outside the map, or an execute step on the shadow in the last field
// touched; a new field is first loaded from the store into the shadow, and
// a completed field write is committed to the store (len of 1 to 4 bytes).
// One item at a time: the next access waits until the reply register loads.
// Synchronous reset; the store reads firmware defaults until each byte is
// first written, with no clearing pass.
// ----------------------------------------------------------------------------
module i2c_register_map_staging_unit import i2crms_pkg::*; (
  input  wire      clk,
  input  wire      rst,
  input  logic     access_valid,
  output logic     access_ready,
  input  access_t  access,
  output logic     reply_valid,
  input  logic     reply_ready,
  output reply_t   reply
);

  ctrl_cmd_t cmd;
  ctrl_sts_t sts;

  // sequencer
  i2crms_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .access_valid (access_valid),
    .access_ready (access_ready),
    .sts          (sts),
    .cmd          (cmd)
  );

  // store, shadow and reply datapath
  i2crms_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .access      (access),
    .reply_ready (reply_ready),
    .cmd         (cmd),
    .sts         (sts),
    .reply       (reply),
    .reply_valid (reply_valid)
  );

endmodule
`default_nettype wire

[design/i2crms_checker.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// i2crms_checker: port-level checks for the staging unit
// Watches the access and reply channels of the top level over time.
// ----------------------------------------------------------------------------
module i2crms_checker import i2crms_pkg::*; (
  input wire      clk,
  input wire      rst,
  input logic     access_valid,
  input logic     access_ready,
  input logic     reply_valid,
  input logic     reply_ready,
  input reply_t   reply
);

  // one item in flight: busy right after an access is taken
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    access_valid && access_ready |=> !access_ready)
    else $error("access taken while an item is in flight");

  // a stalled reply stays put
  a_reply_hold: assert property (@(posedge clk) disable iff (rst)
    reply_valid && !reply_ready |=> reply_valid && $stable(reply))
    else $error("reply dropped or changed while stalled");

  // no reply right out of reset
  a_reset_idle: assert property (@(posedge clk)
    $past(rst) |-> !reply_valid)
    else $error("reply valid right after reset");

  // a committing item is a write and returns no read byte
  a_commit_data: assert property (@(posedge clk) disable iff (rst)
    reply_valid && reply.field_committed |-> reply.read_data == '0)
    else $error("committed write returned read data");

  // only the last field or an unmapped address ends the store
  a_more_flag: assert property (@(posedge clk) disable iff (rst)
    reply_valid && !reply.more_allowed |->
      reply.field_index == '0 || reply.field_index == FIELD_W'(FIELD_COUNT - 1))
    else $error("more flag low inside the store");

endmodule

bind i2c_register_map_staging_unit i2crms_checker u_checker (.*);
`default_nettype wire
